// ----- rtl/core/mips_subset_cpu_step_macros.svh -----
// assertion helpers for the cpu step block
`ifndef MIPS_SUBSET_CPU_STEP_MACROS_SVH
`define MIPS_SUBSET_CPU_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define MSC_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define MSC_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MSC_ASSERT_IMPL(label, clk, rst, prop)
`define MSC_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- rtl/core/msc_pkg.sv -----
package msc_pkg;
   localparam int DataW = 32;
   localparam int PcW = 10;
   // byte memory size, a power of two so that addresses wrap by truncation
   localparam int MemBytes = 1024;

   typedef enum logic [1:0] {
      CMD_WR_MEM  = 2'd0,
      CMD_WR_REG  = 2'd1,
      CMD_EXEC    = 2'd2,
      CMD_RD_REG  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      FAULT_NONE   = 2'd0,
      FAULT_OPCODE = 2'd1,
      FAULT_FUNCT  = 2'd2,
      FAULT_DIV0   = 2'd3
   } fault_type;

   localparam logic [5:0] OP_RTYPE = 6'b000000;
   localparam logic [5:0] OP_J     = 6'b000010;
   localparam logic [5:0] OP_BEQ   = 6'b000100;
   localparam logic [5:0] OP_LW    = 6'b100011;
   localparam logic [5:0] OP_SW    = 6'b101011;
   localparam logic [5:0] FN_ADD   = 6'b100000;
   localparam logic [5:0] FN_SUB   = 6'b100010;
   localparam logic [5:0] FN_SRL   = 6'b000010;
   localparam logic [5:0] FN_MUL   = 6'b011000;
   localparam logic [5:0] FN_DIV   = 6'b011010;

   typedef struct packed {
      logic start;
      logic [DataW-1:0] dividend;
      logic [DataW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DataW-1:0] quotient;
   } div_rsp_type;
endpackage

// ----- rtl/core/mips_subset_cpu_step.sv -----
// one command in flight: a new command is taken only once the response to the
// last has been accepted; the byte memory port and the 32-step divider set the pace
// reset: after reset a clearing pass over every byte address zeroes the byte memory
// and the 32 registers, during which no command is taken
`include "mips_subset_cpu_step_macros.svh"
module mips_subset_cpu_step import msc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[1:0], mem_address[11:2], reg_index[16:12], value[48:17], zero pad
   input  logic [55:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // next_pc[9:0], fetched_word[41:10], reg_written[42], dest_reg[47:43],
   // reg_data[79:48], mem_written[80], store_address[90:81],
   // store_data[122:91], redirected[123], fault[125:124], zero pad
   output logic [127:0] rsp_tdata
);
   localparam int AW = $clog2(MemBytes);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RREAD, S_RDONE, S_MSTORE, S_FETCH, S_DECODE,
      S_OPS, S_EXEC, S_LOAD, S_DIVWAIT, S_WBACK, S_RESP
   } state_type;

   state_type        state_ff;
   logic [AW-1:0]    clr_ff, pc_ff;
   logic [4:0]       idx_ff;
   logic [31:0]      ins_ff, a_ff, b_ff, res_ff, stw_ff;
   logic [AW-1:0]    addr_ff;
   logic [2:0]       step_ff;
   logic             wr_ff;
   logic [4:0]       wreg_ff;
   logic             div_go_ff;

   // result fields
   logic [31:0]   fetch_ff, rdata_ff, sdata_ff;
   logic [4:0]    dreg_ff;
   logic [AW-1:0] saddr_ff;
   logic          rw_ff, mw_ff, redir_ff;
   fault_type     fault_ff;

   // byte memory
   logic          m_we;
   logic [AW-1:0] m_wa, m_ra;
   logic [7:0]    m_wd, m_rd;
   msc_ram #(.Width(8), .Depth(MemBytes)) u_mem (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));

   // register file
   logic        r_we;
   logic [4:0]  r_wa, r_ra;
   logic [31:0] r_wd, r_rd;
   msc_ram #(.Width(32), .Depth(32)) u_regs (
      .clock(clock), .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
      .rd_addr(r_ra), .rd_data(r_rd));

   div_req_type d_req;
   div_rsp_type d_rsp;
   msc_div u_div (.clock(clock), .reset(reset), .req(d_req), .rsp(d_rsp));

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [31:0] sx;
   logic [31:0] prod;
   assign op = ins_ff[31:26];
   assign rs = ins_ff[25:21];
   assign rt = ins_ff[20:16];
   assign rd = ins_ff[15:11];
   assign sh = ins_ff[10:6];
   assign fn = ins_ff[5:0];
   assign sx = {{16{ins_ff[15]}}, ins_ff[15:0]};
   // low word only
   assign prod = a_ff * b_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata = {2'b00, fault_ff, redir_ff, sdata_ff, saddr_ff, mw_ff,
                       rdata_ff, dreg_ff, rw_ff, fetch_ff, pc_ff};
   assign d_req.start = div_go_ff;
   assign d_req.dividend = a_ff;
   assign d_req.divisor = b_ff;

   always_comb begin
      m_we = 1'b0;
      m_wa = addr_ff + AW'(step_ff[1:0]);
      m_wd = stw_ff[31:24];
      m_ra = addr_ff + AW'(step_ff[1:0]);
      r_we = 1'b0;
      r_wa = wreg_ff;
      r_wd = res_ff;
      r_ra = idx_ff;
      unique case (state_ff)
         S_CLEAR: begin
            m_we = 1'b1;
            m_wa = clr_ff;
            m_wd = '0;
            r_we = 1'b1;
            r_wa = clr_ff[4:0];
            r_wd = '0;
         end
         S_MSTORE: m_we = 1'b1;
         S_WBACK: r_we = wr_ff && (wreg_ff != 5'd0);
         S_DECODE: r_ra = rs;
         S_OPS: r_ra = rt;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         pc_ff <= '0;
         div_go_ff <= 1'b0;
      end else begin
         div_go_ff <= (state_ff == S_DIVWAIT) && (fn == FN_DIV) && (b_ff != 32'd0)
                      && (step_ff == 3'd0);
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(MemBytes - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req_tvalid) begin
               idx_ff <= req_tdata[16:12];
               stw_ff <= req_tdata[48:17];
               step_ff <= '0;
               fetch_ff <= '0; rdata_ff <= '0; sdata_ff <= '0; dreg_ff <= '0;
               saddr_ff <= '0; rw_ff <= 1'b0; mw_ff <= 1'b0; redir_ff <= 1'b0;
               fault_ff <= FAULT_NONE;
               wreg_ff <= req_tdata[16:12];
               res_ff <= req_tdata[48:17];
               unique case (cmd_type'(req_tdata[1:0]))
                  CMD_WR_MEM: begin
                     addr_ff <= AW'(req_tdata[11:2]);
                     wr_ff <= 1'b0;
                     mw_ff <= 1'b1;
                     saddr_ff <= AW'(req_tdata[11:2]);
                     sdata_ff <= req_tdata[48:17];
                     state_ff <= S_MSTORE;
                  end
                  CMD_WR_REG: begin
                     addr_ff <= AW'(req_tdata[11:2]);
                     wr_ff <= 1'b1;
                     state_ff <= S_WBACK;
                  end
                  CMD_RD_REG: begin
                     addr_ff <= AW'(req_tdata[11:2]);
                     wr_ff <= 1'b0;
                     state_ff <= S_RREAD;
                  end
                  CMD_EXEC: begin
                     addr_ff <= pc_ff;
                     wr_ff <= 1'b0;
                     state_ff <= S_FETCH;
                  end
               endcase
            end
            S_RREAD: state_ff <= S_RDONE;
            S_RDONE: begin
               dreg_ff <= idx_ff;
               rdata_ff <= (idx_ff == 5'd0) ? 32'd0 : r_rd;
               state_ff <= S_RESP;
            end
            S_MSTORE: begin
               stw_ff <= {stw_ff[23:0], 8'd0};
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd3) state_ff <= S_RESP;
            end
            S_FETCH, S_LOAD: begin
               // byte read issued at step, data arrives in the following cycle
               step_ff <= step_ff + 3'd1;
               if (step_ff != 3'd0) res_ff <= {res_ff[23:0], m_rd};
               if (step_ff == 3'd4) begin
                  if (state_ff == S_FETCH) begin
                     ins_ff <= {res_ff[23:0], m_rd};
                     fetch_ff <= {res_ff[23:0], m_rd};
                     pc_ff <= pc_ff + AW'(4);
                     state_ff <= S_DECODE;
                  end else begin
                     state_ff <= S_WBACK;
                  end
               end
            end
            S_DECODE: state_ff <= S_OPS;
            S_OPS: begin
               a_ff <= (rs == 5'd0) ? 32'd0 : r_rd;
               state_ff <= S_EXEC;
               step_ff <= '0;
            end
            S_EXEC: begin
               b_ff <= (rt == 5'd0) ? 32'd0 : r_rd;
               if (op == OP_LW) begin
                  addr_ff <= AW'(a_ff + sx);
                  wreg_ff <= rt;
                  wr_ff <= 1'b1;
                  state_ff <= S_LOAD;
               end else if (op == OP_SW) begin
                  addr_ff <= AW'(a_ff + sx);
                  saddr_ff <= AW'(a_ff + sx);
                  sdata_ff <= (rt == 5'd0) ? 32'd0 : r_rd;
                  stw_ff <= (rt == 5'd0) ? 32'd0 : r_rd;
                  mw_ff <= 1'b1;
                  state_ff <= S_MSTORE;
               end else if (op == OP_BEQ) begin
                  if (a_ff == ((rt == 5'd0) ? 32'd0 : r_rd)) begin
                     pc_ff <= pc_ff + AW'(sx << 2);
                     redir_ff <= 1'b1;
                  end
                  state_ff <= S_WBACK;
               end else if (op == OP_J) begin
                  pc_ff <= AW'({ins_ff[25:0], 2'b00});
                  redir_ff <= 1'b1;
                  state_ff <= S_WBACK;
               end else if (op == OP_RTYPE) begin
                  wreg_ff <= rd;
                  wr_ff <= 1'b1;
                  state_ff <= S_DIVWAIT;
               end else begin
                  fault_ff <= FAULT_OPCODE;
                  state_ff <= S_WBACK;
               end
            end
            S_DIVWAIT: begin
               // b_ff now holds rt; run the alu step
               if (fn == FN_DIV && b_ff != 32'd0) begin
                  if (step_ff == 3'd0) begin
                     step_ff <= 3'd1;
                  end else if (d_rsp.done) begin
                     res_ff <= d_rsp.quotient;
                     state_ff <= S_WBACK;
                  end
               end else begin
                  state_ff <= S_WBACK;
                  if (fn == FN_ADD) res_ff <= a_ff + b_ff;
                  else if (fn == FN_SUB) res_ff <= a_ff - b_ff;
                  else if (fn == FN_SRL) res_ff <= a_ff >> sh;
                  else if (fn == FN_MUL) res_ff <= prod;
                  else if (fn == FN_DIV) begin
                     wr_ff <= 1'b0;
                     fault_ff <= FAULT_DIV0;
                  end else begin
                     wr_ff <= 1'b0;
                     fault_ff <= FAULT_FUNCT;
                  end
               end
            end
            S_WBACK: begin
               if (wr_ff && wreg_ff != 5'd0) begin
                  rw_ff <= 1'b1;
                  dreg_ff <= wreg_ff;
                  rdata_ff <= res_ff;
               end
               state_ff <= S_RESP;
            end
            S_RESP: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `MSC_ASSERT_IMPL(a_one_side, clock, reset, !(req_tready && rsp_tvalid))
   `MSC_ASSERT_IMPL(a_rsp_after_work, clock, reset, $rose(rsp_tvalid) |-> $past(!req_tready))
   `MSC_ASSERT_NORST(a_reset_clears, clock, reset |=> !req_tready && !rsp_tvalid)
endmodule

// ----- rtl/core/msc_ram.sv -----
module msc_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/msc_div.sv -----
module msc_div import msc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [DataW-1:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [DataW:0]   trial;
   logic [DataW-1:0] shifted;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DataW-2:0], quo_ff[DataW-1]};
      trial = {1'b0, shifted} - {1'b0, den_ff};
      if (req.start) begin
         quo_in = req.dividend[DataW-1] ? 32'd0 - req.dividend : req.dividend;
         den_in = req.divisor[DataW-1] ? 32'd0 - req.divisor : req.divisor;
         rem_in = '0;
         cnt_in = '0;
         neg_in = req.dividend[DataW-1] ^ req.divisor[DataW-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         if (rem_ff[DataW-1] || !trial[DataW]) begin
            rem_in = trial[DataW-1:0];
            quo_in = {quo_ff[DataW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DataW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = neg_ff ? 32'd0 - quo_ff : quo_ff;
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import msc_pkg::*;

   typedef struct packed {
      logic [1:0]  fault;
      logic        redirected;
      logic [31:0] store_data;
      logic [9:0]  store_address;
      logic        mem_written;
      logic [31:0] reg_data;
      logic [4:0]  dest_reg;
      logic        reg_written;
      logic [31:0] fetched_word;
      logic [9:0]  next_pc;
   } step_result_type;

   class cpu_scoreboard;
      logic [31:0] regs [32];
      logic [7:0]  bytes [1024];
      logic [9:0]  pc;
      step_result_type pending [$];
      int errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (bytes[i]) bytes[i] = '0;
         pc = '0;
         errors = 0;
      endfunction

      function logic [31:0] rd_word(logic [9:0] a);
         logic [31:0] w;
         w = '0;
         for (int i = 0; i < 4; i++) w = {w[23:0], bytes[10'(a + i)]};
         return w;
      endfunction

      function void wr_word(logic [9:0] a, logic [31:0] w);
         for (int i = 0; i < 4; i++) bytes[10'(a + i)] = w[31 - 8*i -: 8];
      endfunction

      function logic [31:0] sdiv(logic [31:0] x, logic [31:0] y);
         logic [31:0] ux, uy, q;
         ux = x[31] ? -x : x;
         uy = y[31] ? -y : y;
         q = ux / uy;
         return (x[31] != y[31]) ? -q : q;
      endfunction

      function void note_command(cmd_type cmd, logic [9:0] maddr, logic [4:0] ridx,
                                 logic [31:0] val);
         step_result_type r;
         logic [31:0] ins, a, b, sx, res;
         logic [4:0] wreg;
         logic wr;
         r = '0;
         case (cmd)
            CMD_WR_MEM: begin
               wr_word(maddr, val);
               r.mem_written = 1; r.store_address = maddr; r.store_data = val;
            end
            CMD_WR_REG: begin
               if (ridx != 0) begin
                  regs[ridx] = val;
                  r.reg_written = 1; r.dest_reg = ridx; r.reg_data = val;
               end
            end
            CMD_RD_REG: begin
               r.dest_reg = ridx;
               r.reg_data = ridx ? regs[ridx] : '0;
            end
            default: begin
               ins = rd_word(pc);
               r.fetched_word = ins;
               a = ins[25:21] ? regs[ins[25:21]] : '0;
               b = ins[20:16] ? regs[ins[20:16]] : '0;
               sx = {{16{ins[15]}}, ins[15:0]};
               pc = 10'(pc + 4);
               wr = 0; wreg = '0; res = '0;
               case (ins[31:26])
                  OP_LW: begin
                     res = rd_word(10'(a + sx)); wreg = ins[20:16]; wr = 1;
                  end
                  OP_SW: begin
                     r.store_address = 10'(a + sx); r.store_data = b; r.mem_written = 1;
                     wr_word(r.store_address, b);
                  end
                  OP_BEQ: begin
                     if (a == b) begin
                        pc = 10'(pc + (sx << 2)); r.redirected = 1;
                     end
                  end
                  OP_J: begin
                     pc = 10'(ins[25:0] << 2); r.redirected = 1;
                  end
                  OP_RTYPE: begin
                     wreg = ins[15:11]; wr = 1;
                     case (ins[5:0])
                        FN_ADD: res = a + b;
                        FN_SUB: res = a - b;
                        FN_SRL: res = a >> ins[10:6];
                        FN_MUL: res = a * b;
                        FN_DIV: begin
                           if (b == 0) begin
                              r.fault = FAULT_DIV0; wr = 0;
                           end else res = sdiv(a, b);
                        end
                        default: begin
                           r.fault = FAULT_FUNCT; wr = 0;
                        end
                     endcase
                  end
                  default: r.fault = FAULT_OPCODE;
               endcase
               if (wr && wreg != 0) begin
                  regs[wreg] = res;
                  r.reg_written = 1; r.dest_reg = wreg; r.reg_data = res;
               end
            end
         endcase
         r.next_pc = pc;
         pending.push_back(r);
      endfunction

      function void check_result(logic [127:0] data);
         step_result_type got, exp;
         got = data[125:0];
         if (data[127:126] != 0) begin
            $display("%0t pad bits set: %h", $time, data);
            errors++;
         end
         if (pending.size() == 0) begin
            $display("%0t unexpected result %h", $time, data);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.next_pc != exp.next_pc) report("next_pc", exp.next_pc, got.next_pc);
         if (got.fetched_word != exp.fetched_word)
            report("fetched_word", exp.fetched_word, got.fetched_word);
         if (got.reg_written != exp.reg_written)
            report("reg_written", exp.reg_written, got.reg_written);
         if (got.dest_reg != exp.dest_reg) report("dest_reg", exp.dest_reg, got.dest_reg);
         if (got.reg_data != exp.reg_data) report("reg_data", exp.reg_data, got.reg_data);
         if (got.mem_written != exp.mem_written)
            report("mem_written", exp.mem_written, got.mem_written);
         if (got.store_address != exp.store_address)
            report("store_address", exp.store_address, got.store_address);
         if (got.store_data != exp.store_data)
            report("store_data", exp.store_data, got.store_data);
         if (got.redirected != exp.redirected)
            report("redirected", exp.redirected, got.redirected);
         if (got.fault != exp.fault) report("fault", exp.fault, got.fault);
      endfunction

      function void report(string fld, logic [31:0] e, logic [31:0] g);
         $display("%0t %s mismatch: expected %h actual %h", $time, fld, e, g);
         errors++;
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [55:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;

   cpu_scoreboard sb = new();
   bit hold_off = 0;
   bit stim_done = 0;
   longint cycles = 0;

   mips_subset_cpu_step u_top (.*);

   initial forever #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // receiver: random stall pattern, long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_off) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(0, 3) != 0) || (cycles[9:8] == 2'b01);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   task automatic send(cmd_type cmd, logic [9:0] maddr, logic [4:0] ridx, logic [31:0] val);
      req_tvalid <= 1;
      req_tdata <= {7'b0, val, ridx, maddr, cmd};
      do @(posedge clock); while (!req_tready);
      sb.note_command(cmd, maddr, ridx, val);
   endtask

   task automatic idle(int n);
      req_tvalid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // place instruction at pc and run it
   task automatic run_ins(logic [31:0] ins);
      send(CMD_WR_MEM, sb.pc, 0, ins);
      send(CMD_EXEC, 0, 0, 0);
   endtask

   function automatic logic [31:0] rtype(logic [4:0] rs, rt, rd, sh, logic [5:0] fn);
      return {OP_RTYPE, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] rand_ins();
      logic [5:0] fns [5] = '{FN_ADD, FN_SUB, FN_SRL, FN_MUL, FN_DIV};
      logic [4:0] rs, rt;
      rs = 5'($urandom_range(0, 7));
      rt = 5'($urandom_range(0, 7));
      case ($urandom_range(0, 11))
         0, 1: return itype(OP_LW, rs, rt, 16'($urandom_range(0, 2047) - 1024));
         2, 3: return itype(OP_SW, rs, rt, 16'($urandom_range(0, 2047) - 1024));
         4: return itype(OP_BEQ, rs, rt, 16'($urandom));
         5: return {OP_J, 26'($urandom)};
         6: return $urandom;
         7: return rtype(rs, rt, 5'($urandom_range(0, 7)), 5'($urandom), 6'($urandom));
         default: return rtype(rs, rt, 5'($urandom_range(0, 7)), 5'($urandom),
                               fns[$urandom_range(0, 4)]);
      endcase
   endfunction

   initial begin
      int burst;
      repeat (4) @(posedge clock);
      reset <= 0;
      // directed
      send(CMD_RD_REG, 0, 5, 0);
      send(CMD_WR_REG, 0, 0, 32'hFFFF_FFFF);
      send(CMD_WR_REG, 0, 31, 32'hFFFF_FFFF);
      send(CMD_RD_REG, 0, 31, 0);
      send(CMD_RD_REG, 0, 0, 0);
      send(CMD_WR_REG, 0, 1, 32'h8000_0000);
      send(CMD_WR_REG, 0, 2, 32'd7);
      send(CMD_WR_MEM, 10'h3FE, 0, 32'hA1B2_C3D4);
      run_ins(rtype(1, 31, 3, 0, FN_DIV));
      run_ins(rtype(1, 0, 4, 0, FN_DIV));
      run_ins(rtype(1, 2, 5, 0, FN_ADD));
      run_ins(rtype(1, 2, 6, 0, FN_SUB));
      run_ins(rtype(1, 0, 7, 31, FN_SRL));
      run_ins(rtype(31, 2, 0, 0, FN_MUL));
      run_ins(rtype(1, 2, 8, 0, 6'h3F));
      run_ins(itype(6'h3F, 0, 0, 0));
      run_ins(itype(OP_SW, 0, 31, 16'hFFFE));
      run_ins(itype(OP_LW, 0, 9, 16'h03FE));
      run_ins(itype(OP_BEQ, 0, 0, 16'h8000));
      run_ins({OP_J, 26'h3FF_FFFF});
      drain();
      // long receiver hold-off while sending
      hold_off = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 6; i++) send(CMD_WR_REG, 0, 5'(i + 1), $urandom);
      join
      drain();
      // random
      for (int n = 0; n < 500; ) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst; k++) begin
            case ($urandom_range(0, 9))
               0: send(CMD_WR_MEM, 10'($urandom), 0, $urandom);
               1: send(CMD_WR_REG, 0, 5'($urandom),
                       $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 40)));
               2: send(CMD_RD_REG, 0, 5'($urandom), 0);
               3: send(CMD_EXEC, 0, 0, 0);
               default: begin
                  run_ins(rand_ins());
                  n++;
               end
            endcase
            n++;
         end
         if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 20));
         if (n % 100 < 10 && $urandom_range(0, 3) == 0) drain();
      end
      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/msc_pkg.sv
rtl/core/msc_ram.sv
rtl/core/msc_div.sv
rtl/core/mips_subset_cpu_step.sv
dv/tb_top.sv
